>>> rtl/dvrt_pkg.sv
`timescale 1ns / 1ps
package dvrt_pkg;
  typedef enum logic [1:0] {
    ACT_NEIGHBOR = 2'd0,
    ACT_OWN      = 2'd1,
    ACT_ADVERT   = 2'd2,
    ACT_READ     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_NO_CHANGE = 3'd0,
    ST_ADDED     = 3'd1,
    ST_IMPROVED  = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    logic [15:0] cost;
    logic        last;
    logic [4:0]  slot;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] route_cost;
    logic [31:0] hop_addr;
    logic [15:0] hop_port;
    logic [31:0] route_dest_addr;
    logic [15:0] route_dest_port;
    logic        slot_valid;
    logic        converged;
  } out_item_t;

  localparam int unsigned KeyW = 48;
  localparam int unsigned CostW = 16;
  localparam logic [CostW-1:0] CostMax = '1;
  localparam logic [3:0] CountMax = 4'd15;
endpackage

>>> rtl/dvrt_fifo.sv
`timescale 1ns / 1ps
module dvrt_fifo
  import dvrt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_stall,
  input  in_item_t wr_item,
  output logic     rd_valid,
  input  logic     rd_take,
  output in_item_t rd_item
);
  in_item_t   mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rp_r];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && rd_take;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= wr_item;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) (cnt_r == 2'd0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2)
    else $error("full queue lost an entry");
endmodule

>>> rtl/dvrt_engine.sv
`timescale 1ns / 1ps
module dvrt_engine
  import dvrt_pkg::*;
#(
  parameter int unsigned ROUTE_ENTRIES    = 32,
  parameter int unsigned NEIGHBOR_ENTRIES = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_take,
  input  in_item_t  q_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);
  localparam int unsigned RW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int unsigned NW = (NEIGHBOR_ENTRIES > 1) ? $clog2(NEIGHBOR_ENTRIES) : 1;

  logic [ROUTE_ENTRIES-1:0]    rvalid_r;
  logic [KeyW-1:0]             rkey_r  [ROUTE_ENTRIES];
  logic [CostW-1:0]            rmet_r  [ROUTE_ENTRIES];
  logic [KeyW-1:0]             rhop_r  [ROUTE_ENTRIES];
  logic [NEIGHBOR_ENTRIES-1:0] nvalid_r;
  logic [KeyW-1:0]             nkey_r  [NEIGHBOR_ENTRIES];
  logic [CostW-1:0]            nmet_r  [NEIGHBOR_ENTRIES];
  logic [3:0] ncount_r, quiet_r;
  logic       changed_r;

  // stage 1 registers: lookup results
  logic            s1_r;
  in_item_t        it_r;
  logic            rhit_r, rfree_ok_r, nhit_r, nfree_ok_r;
  logic [RW-1:0]   ridx_r, rfree_r;
  logic [NW-1:0]   nidx_r, nfree_r;

  logic            outv_r;
  out_item_t       out_r;

  logic [KeyW-1:0] peer, dest, lkey;
  logic            rhit, rfok, nhit, nfok;
  logic [RW-1:0]   ridx, rfree;
  logic [NW-1:0]   nidx, nfree;

  assign peer = {q_item.peer_addr, q_item.peer_port};
  assign dest = {q_item.dest_addr, q_item.dest_port};
  assign lkey = (q_item.action == ACT_NEIGHBOR) ? peer : dest;

  always_comb begin
    rhit = 1'b0; rfok = 1'b0; ridx = '0; rfree = '0;
    for (int i = ROUTE_ENTRIES - 1; i >= 0; i--) begin
      if (rvalid_r[i] && rkey_r[i] == lkey) begin
        rhit = 1'b1; ridx = RW'(i);
      end
      if (!rvalid_r[i]) begin
        rfok = 1'b1; rfree = RW'(i);
      end
    end
    nhit = 1'b0; nfok = 1'b0; nidx = '0; nfree = '0;
    for (int j = NEIGHBOR_ENTRIES - 1; j >= 0; j--) begin
      if (nvalid_r[j] && nkey_r[j] == peer) begin
        nhit = 1'b1; nidx = NW'(j);
      end
      if (!nvalid_r[j]) begin
        nfok = 1'b1; nfree = NW'(j);
      end
    end
  end

  // one item at a time: lookup cycle, then update cycle
  logic out_free;
  assign out_free = !outv_r || !out_stall;
  assign q_take   = q_valid && !s1_r && out_free;
  assign out_valid = outv_r;
  assign out_data  = out_r;

  // stage 2: decide and write
  logic [KeyW-1:0] s_peer, s_dest;
  logic [16:0]     sum_w;
  logic [CostW-1:0] sum;
  logic [RW-1:0]   tgt;
  logic            wr_route, wr_nb_new, wr_nb_met, mark_chg, do_last, show, ok;
  logic [KeyW-1:0] w_key, w_hop;
  logic [CostW-1:0] w_met;
  status_t         st;
  logic [3:0]      quiet_nxt, ncount_nxt;
  logic            changed_nxt;
  out_item_t       res;

  assign s_peer = {it_r.peer_addr, it_r.peer_port};
  assign s_dest = {it_r.dest_addr, it_r.dest_port};
  assign sum_w  = {1'b0, it_r.cost} + {1'b0, nmet_r[nidx_r]};
  assign sum    = sum_w[16] ? CostMax : sum_w[CostW-1:0];

  always_comb begin
    wr_route = 1'b0; wr_nb_new = 1'b0; wr_nb_met = 1'b0; mark_chg = 1'b0;
    do_last = 1'b0; show = 1'b0; ok = 1'b0;
    tgt = rhit_r ? ridx_r : rfree_r;
    w_key = s_dest; w_hop = s_dest; w_met = '0;
    st = ST_NO_CHANGE;
    case (action_t'(it_r.action))
      ACT_NEIGHBOR: begin
        ok = (nhit_r || nfree_ok_r) && (rhit_r || rfree_ok_r);
        if (!ok) st = ST_FULL;
        else begin
          wr_nb_new = !nhit_r; wr_nb_met = 1'b1; wr_route = 1'b1; show = 1'b1;
          w_key = s_peer; w_hop = s_peer; w_met = it_r.cost;
          st = rhit_r ? ST_IMPROVED : ST_ADDED;
        end
      end
      ACT_OWN: begin
        if (!(rhit_r || rfree_ok_r)) st = ST_FULL;
        else begin
          wr_route = 1'b1; show = 1'b1;
          st = rhit_r ? ST_IMPROVED : ST_ADDED;
        end
      end
      ACT_ADVERT: begin
        if (!nhit_r) st = ST_UNKNOWN;
        else begin
          do_last = it_r.last;
          w_hop = s_peer; w_met = sum;
          if (!rhit_r) begin
            if (!rfree_ok_r) st = ST_FULL;
            else begin
              wr_route = 1'b1; mark_chg = 1'b1; show = 1'b1; st = ST_ADDED;
            end
          end else begin
            show = 1'b1;
            if (sum < rmet_r[ridx_r]) begin
              wr_route = 1'b1; mark_chg = 1'b1; st = ST_IMPROVED;
            end
          end
        end
      end
      default: begin
        tgt  = RW'(it_r.slot);
        show = ({27'd0, it_r.slot} < 32'(ROUTE_ENTRIES)) && rvalid_r[tgt];
      end
    endcase
  end

  always_comb begin
    changed_nxt = changed_r || mark_chg;
    quiet_nxt   = quiet_r;
    if (do_last) begin
      if (changed_nxt) quiet_nxt = '0;
      else if (quiet_r < CountMax) quiet_nxt = quiet_r + 4'd1;
      changed_nxt = 1'b0;
    end
    ncount_nxt = (wr_nb_new && ncount_r < CountMax) ? ncount_r + 4'd1 : ncount_r;
  end

  always_comb begin
    res = '0;
    res.status = st;
    if (show) begin
      if (wr_route) begin
        res.route_cost = w_met;
        {res.hop_addr, res.hop_port} = w_hop;
        {res.route_dest_addr, res.route_dest_port} = w_key;
      end else begin
        res.route_cost = rmet_r[tgt];
        {res.hop_addr, res.hop_port} = rhop_r[tgt];
        {res.route_dest_addr, res.route_dest_port} = rkey_r[tgt];
      end
      res.slot_valid = 1'b1;
    end
    res.converged = quiet_nxt > ncount_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r      <= 1'b0;
      outv_r    <= 1'b0;
      rvalid_r  <= '0;
      nvalid_r  <= '0;
      ncount_r  <= '0;
      quiet_r   <= '0;
      changed_r <= 1'b0;
    end else begin
      if (q_take) s1_r <= 1'b1;
      else if (s1_r) s1_r <= 1'b0;
      if (s1_r) outv_r <= 1'b1;
      else if (!out_stall) outv_r <= 1'b0;
      if (s1_r) begin
        if (wr_route) rvalid_r[tgt] <= 1'b1;
        if (wr_nb_new) nvalid_r[nfree_r] <= 1'b1;
        ncount_r  <= ncount_nxt;
        quiet_r   <= quiet_nxt;
        changed_r <= changed_nxt;
      end
    end
    if (q_take) begin
      it_r <= q_item;
      rhit_r <= rhit; rfree_ok_r <= rfok; ridx_r <= ridx; rfree_r <= rfree;
      nhit_r <= nhit; nfree_ok_r <= nfok; nidx_r <= nidx; nfree_r <= nfree;
    end
    if (s1_r) begin
      out_r <= res;
      if (wr_route) begin
        rkey_r[tgt] <= w_key; rhop_r[tgt] <= w_hop; rmet_r[tgt] <= w_met;
      end
      if (wr_nb_new) nkey_r[nfree_r] <= s_peer;
      if (wr_nb_met) nmet_r[nhit_r ? nidx_r : nfree_r] <= it_r.cost;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) s1_r |=> !s1_r)
    else $error("lookup stage held two cycles");
  assert property (@(posedge clk) disable iff (!rst_n) s1_r |=> outv_r)
    else $error("result not registered after update");
  assert property (@(posedge clk) disable iff (!rst_n) (outv_r && out_stall) |-> !q_take)
    else $error("item taken while result blocked");
  assert property (@(posedge clk) disable iff (!rst_n) ncount_r <= CountMax)
    else $error("neighbor count overflow");
endmodule

>>> rtl/distance_vector_route_table_core.sv
`timescale 1ns / 1ps
// Distance-vector route table: every request gives exactly one result.
// Requests enter a two-deep queue, so the input is taken while a result waits.
// The engine handles one request at a time: parallel key match over all route
// and neighbor entries into registers, then relaxation and table write, then
// an output register. A new request is taken only after the last is written
// and while the output register is free or draining. Costs are unsigned 12.4.
module distance_vector_route_table_core
  import dvrt_pkg::*;
#(
  parameter int unsigned ROUTE_ENTRIES    = 32,
  parameter int unsigned NEIGHBOR_ENTRIES = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);
  logic     q_valid, q_take;
  in_item_t q_item;

  dvrt_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(in_valid), .wr_stall(in_stall), .wr_item(in_data),
    .rd_valid(q_valid), .rd_take(q_take), .rd_item(q_item)
  );

  dvrt_engine #(
    .ROUTE_ENTRIES(ROUTE_ENTRIES), .NEIGHBOR_ENTRIES(NEIGHBOR_ENTRIES)
  ) u_engine (
    .clk, .rst_n,
    .q_valid, .q_take, .q_item,
    .out_valid, .out_stall, .out_data
  );
endmodule
